>>> hw/rtl/imn_pkg.sv
// ---------------------------------------------------------------------------
// imn_pkg: shared types and constants for the masked image norm block
// Pixel and result formats, lane and finish records, mode and register codes.
// ---------------------------------------------------------------------------
package imn_pkg;

  localparam int PIX_W   = 8;
  localparam int SQ_W    = 16;
  localparam int LSUM_W  = 18;
  localparam int ACC_W   = 40;
  localparam int NORM_W  = 32;
  localparam int ROOT_W  = 20;
  localparam int REM_W   = 24;
  localparam int CNT_W   = 5;
  localparam int CHANS   = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 3;

  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  localparam logic [1:0] MODE_L1  = 2'd0;
  localparam logic [1:0] MODE_L2  = 2'd1;
  localparam logic [1:0] MODE_INF = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_NORM_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_USE_MASK  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHAN_CNT  = 2'd2;

  typedef struct packed {
    logic [7:0] chan0;
    logic [7:0] chan1;
    logic [7:0] chan2;
    logic [7:0] chan3;
    logic [7:0] mask_byte;
    logic       last_pixel;
  } pix_t;

  typedef struct packed {
    logic [31:0] norm_value;
    logic [39:0] square_sum;
    logic        overflowed;
  } res_t;

  typedef struct packed {
    logic [PIX_W-1:0] val;
    logic [SQ_W-1:0]  sq;
  } lane_res_t;

  typedef struct packed {
    logic [ACC_W-1:0] sum;
    logic [PIX_W-1:0] max;
    logic             sat;
    logic [1:0]       mode;
  } fin_t;

endpackage

>>> hw/rtl/imn_lane.sv
// ---------------------------------------------------------------------------
// imn_lane: one channel lane
// Applies the mask and lane enable to one channel byte and registers the
// value together with its square.
// ---------------------------------------------------------------------------
module imn_lane
  import imn_pkg::*;
(
  input  logic             clk,
  input  logic             load,
  input  logic [PIX_W-1:0] chan_i,
  input  logic             active_i,
  input  logic             keep_i,
  output lane_res_t        res_o
);

  logic [PIX_W-1:0] v;
  lane_res_t        res_r;
  lane_res_t        res_nxt;

  always_comb begin
    v           = (active_i && keep_i) ? chan_i : '0;
    res_nxt.val = v;
    res_nxt.sq  = SQ_W'(v) * SQ_W'(v);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  assign res_o = res_r;

endmodule

>>> hw/rtl/imn_merge.sv
// ---------------------------------------------------------------------------
// imn_merge: lane merge and image accumulator
// Sums or maximizes the lane results of one pixel and folds them into the
// saturating running sum and the running maximum.
// ---------------------------------------------------------------------------
module imn_merge
  import imn_pkg::*;
#(
  parameter int LANES = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic       last,
  input  logic [1:0] mode,
  input  lane_res_t  lane_i [LANES],
  output fin_t       fin_o
);

  logic [ACC_W-1:0]  sum_r, sum_nxt;
  logic [PIX_W-1:0]  max_r, max_nxt;
  logic              sat_r, sat_nxt;
  logic [LSUM_W-1:0] val_sum, sq_sum, add;
  logic [ACC_W:0]    sum_ext;

  always_comb begin
    val_sum = '0;
    sq_sum  = '0;
    max_nxt = max_r;
    for (int k = 0; k < LANES; k++) begin
      val_sum = val_sum + LSUM_W'(lane_i[k].val);
      sq_sum  = sq_sum + LSUM_W'(lane_i[k].sq);
      if (lane_i[k].val > max_nxt) begin
        max_nxt = lane_i[k].val;
      end
    end
    add     = (mode == MODE_L1) ? val_sum : sq_sum;
    sum_ext = {1'b0, sum_r} + (ACC_W+1)'(add);
    sum_nxt = sum_r;
    sat_nxt = sat_r;
    if (mode != MODE_INF) begin
      if (sum_ext[ACC_W]) begin
        sum_nxt = ACC_MAX;
        sat_nxt = 1'b1;
      end else begin
        sum_nxt = sum_ext[ACC_W-1:0];
      end
    end
    fin_o.sum  = sum_nxt;
    fin_o.max  = max_nxt;
    fin_o.sat  = sat_nxt;
    fin_o.mode = mode;
  end

  // The last pixel of an image hands its totals on and clears the accumulators.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      max_r <= '0;
      sat_r <= 1'b0;
    end else if (step) begin
      if (last) begin
        sum_r <= '0;
        max_r <= '0;
        sat_r <= 1'b0;
      end else begin
        sum_r <= sum_nxt;
        max_r <= max_nxt;
        sat_r <= sat_nxt;
      end
    end
  end

`ifndef SYNTHESIS
  a_sat_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (sat_r && !(step && last)) |=> sat_r)
    else $error("saturation flag dropped inside an image");

  a_sat_full: assert property (@(posedge clk) disable iff (!rst_n)
    sat_r |-> (sum_r == ACC_MAX))
    else $error("saturated accumulator is not at its limit");
`endif

endmodule

>>> hw/rtl/imn_sqrt.sv
// ---------------------------------------------------------------------------
// imn_sqrt: iterative floor square root
// Restoring square root, one result bit per cycle, over the full sum width.
// ---------------------------------------------------------------------------
module imn_sqrt
  import imn_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [ACC_W-1:0]  operand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ACC_W-1:0]  op_r, op_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [REM_W-1:0]  rem_ext, trial;

  always_comb begin
    rem_ext  = {rem_r[REM_W-3:0], op_r[ACC_W-1 -: 2]};
    trial    = {{(REM_W-ROOT_W-2){1'b0}}, root_r, 2'b01};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    op_nxt   = op_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(ROOT_W - 1);
      op_nxt   = operand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      op_nxt = {op_r[ACC_W-3:0], 2'b00};
      if (rem_ext >= trial) begin
        rem_nxt  = rem_ext - trial;
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_ext;
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("square root started while busy");
`endif

endmodule

>>> hw/rtl/masked_image_norm_top.sv
// ---------------------------------------------------------------------------
// masked_image_norm_top: streaming masked L1 / L2 / INF image norm
// Channel lanes mask and square each pixel, a merge stage accumulates the
// image, and one result per image leaves after its last pixel.
// ---------------------------------------------------------------------------
//  Channel  Direction  Handshake              Payload
//  in_      input      in_valid / in_stall    pix_t: four channels, mask, last
//  out_     output     out_valid / out_stall  res_t: norm, square sum, overflow
//  cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Pixels are taken one per cycle while in_stall is low. After a last pixel the
// input stalls while the image is finished; for L2 the finish also runs the
// bit-serial square root over the 20 result bits. A result waiting in the
// output register does not stop the next image from streaming in; only its
// finish waits for the register to drain. Reset is synchronous, clears the
// accumulators and resets the configuration; cfg_ready is always high.
// ---------------------------------------------------------------------------
module masked_image_norm_top
  import imn_pkg::*;
#(
  parameter int LANES = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pix_t                 in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output res_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam logic [1:0] FS_IDLE = 2'd0;
  localparam logic [1:0] FS_HOLD = 2'd1;
  localparam logic [1:0] FS_ROOT = 2'd2;
  localparam logic [1:0] FS_EMIT = 2'd3;

  logic [1:0]        norm_mode_r;
  logic              use_mask_r;
  logic [2:0]        chan_cnt_r;
  logic [2:0]        eff_cnt;
  logic [1:0]        mode_eff;
  logic              keep;
  logic              in_acc;
  logic [PIX_W-1:0]  chan_a [CHANS];
  lane_res_t         lane_res [LANES];

  logic              s1_vld_r, s1_last_r;
  logic [1:0]        s1_mode_r;
  fin_t              merge_fin;
  fin_t              fin_r;
  logic [1:0]        fst_r, fst_nxt;
  logic              root_start, root_done;
  logic [ROOT_W-1:0] root;
  logic              out_free;
  logic              out_load;
  logic              out_valid_r;
  res_t              out_data_r, res_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      norm_mode_r <= MODE_L1;
      use_mask_r  <= 1'b0;
      chan_cnt_r  <= 3'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_NORM_MODE: norm_mode_r <= cfg_data[1:0];
        REG_USE_MASK:  use_mask_r  <= cfg_data[0];
        REG_CHAN_CNT:  chan_cnt_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (chan_cnt_r == 3'd0) begin
      eff_cnt = 3'd1;
    end else if (chan_cnt_r > 3'(LANES)) begin
      eff_cnt = 3'(LANES);
    end else begin
      eff_cnt = chan_cnt_r;
    end
    mode_eff = (norm_mode_r == MODE_L1 || norm_mode_r == MODE_L2) ? norm_mode_r : MODE_INF;
    keep     = !(use_mask_r && in_data.mask_byte == 8'd0);
  end

  assign chan_a[0] = in_data.chan0;
  assign chan_a[1] = in_data.chan1;
  assign chan_a[2] = in_data.chan2;
  assign chan_a[3] = in_data.chan3;

  // An image's finish owns the input until its result sits in the output register.
  assign in_stall = (s1_vld_r && s1_last_r) || (fst_r != FS_IDLE);
  assign in_acc   = in_valid && !in_stall;

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    imn_lane u_lane (
      .clk      (clk),
      .load     (in_acc),
      .chan_i   (chan_a[k]),
      .active_i (3'(k) < eff_cnt),
      .keep_i   (keep),
      .res_o    (lane_res[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_last_r <= in_data.last_pixel;
      s1_mode_r <= mode_eff;
    end
  end

  imn_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (s1_vld_r),
    .last   (s1_last_r),
    .mode   (s1_mode_r),
    .lane_i (lane_res),
    .fin_o  (merge_fin)
  );

  imn_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (root_start),
    .operand (fin_r.sum),
    .done    (root_done),
    .root    (root)
  );

  assign out_free   = !out_valid_r || !out_stall;
  assign root_start = (fst_r == FS_HOLD) && (fin_r.mode == MODE_L2);
  assign out_load   = (fst_r == FS_EMIT) && out_free;

  always_comb begin
    fst_nxt = fst_r;
    case (fst_r)
      FS_IDLE: if (s1_vld_r && s1_last_r) fst_nxt = FS_HOLD;
      FS_HOLD: fst_nxt = (fin_r.mode == MODE_L2) ? FS_ROOT : FS_EMIT;
      FS_ROOT: if (root_done) fst_nxt = FS_EMIT;
      FS_EMIT: if (out_free) fst_nxt = FS_IDLE;
      default: fst_nxt = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fst_r <= FS_IDLE;
    end else begin
      fst_r <= fst_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fst_r == FS_IDLE && s1_vld_r && s1_last_r) begin
      fin_r <= merge_fin;
    end
  end

  always_comb begin
    res_nxt.square_sum = '0;
    res_nxt.overflowed = fin_r.sat;
    case (fin_r.mode)
      MODE_L1: begin
        if (fin_r.sum[ACC_W-1:NORM_W] != '0) begin
          res_nxt.norm_value = {NORM_W{1'b1}};
          res_nxt.overflowed = 1'b1;
        end else begin
          res_nxt.norm_value = fin_r.sum[NORM_W-1:0];
        end
      end
      MODE_L2: begin
        res_nxt.norm_value = NORM_W'(root);
        res_nxt.square_sum = fin_r.sum;
      end
      default: res_nxt.norm_value = NORM_W'(fin_r.max);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.last_pixel) |=> in_stall)
    else $error("input not stalled after a last pixel transfer");

  a_root_exact: assert property (@(posedge clk) disable iff (!rst_n)
    (fst_r == FS_ROOT && root_done) |->
      ((64'(root) * 64'(root) <= 64'(fin_r.sum)) &&
       ((64'(root) + 64'd1) * (64'(root) + 64'd1) > 64'(fin_r.sum))))
    else $error("square root result out of range");
`endif

endmodule
